// File: hw/rtl/fsa_pkg.sv
// ----------------------------------------------------------------------------
// fsa_pkg
// Shared widths, codes and types of the fraction sum accumulator
// ----------------------------------------------------------------------------
package fsa_pkg;

  // payload widths
  localparam int VALUE_BITS = 16;
  localparam int ACC_BITS   = 63;

  // divider digit and working widths
  localparam int DIGIT_BITS    = 4;
  localparam int WIDE_BITS     = ((ACC_BITS + VALUE_BITS + 1 + DIGIT_BITS - 1) / DIGIT_BITS)
                                 * DIGIT_BITS;
  localparam int WIDE_STEPS    = WIDE_BITS / DIGIT_BITS;
  localparam int SHORT_STEPS   = (VALUE_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int SHORT_BITS    = SHORT_STEPS * DIGIT_BITS;
  localparam int STEP_CNT_BITS = $clog2(WIDE_STEPS + 1);

  // stream widths, whole bytes
  localparam int IN_TDATA_BITS  = ((2 * VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = ((2 * ACC_BITS + 7) / 8) * 8;

  // register port
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;
  localparam logic REG_INTEGER_MODE = 1'b0;  // word index of integer_mode

  typedef enum logic [1:0] {
    ALU_DIV_SHORT,
    ALU_DIV_WIDE,
    ALU_MUL
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_GCD_CHK,
    ST_GCD_WAIT,
    ST_N_DIV,
    ST_N_WAIT,
    ST_D_DIV,
    ST_D_WAIT,
    ST_G_MOD,
    ST_G_WAIT,
    ST_AP_DIV,
    ST_AP_WAIT,
    ST_DP_DIV,
    ST_DP_WAIT,
    ST_MUL_A,
    ST_MUL_A_WAIT,
    ST_MUL_B,
    ST_MUL_B_WAIT,
    ST_MUL_C,
    ST_MUL_C_WAIT,
    ST_R_MOD,
    ST_R_WAIT,
    ST_NUM_DIV,
    ST_NUM_WAIT,
    ST_DEN_DIV,
    ST_DEN_WAIT,
    ST_UPDATE,
    ST_EMIT
  } fsa_state_e;

endpackage

// File: hw/rtl/fsa_alu.sv
// ----------------------------------------------------------------------------
// fsa_alu
// Shared arithmetic unit: digit-serial divider and multiplier
// ----------------------------------------------------------------------------
module fsa_alu (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fsa_pkg::alu_req_t                   req_i,
  input  logic [fsa_pkg::WIDE_BITS-1:0]       a_i,
  input  logic [fsa_pkg::VALUE_BITS-1:0]      b_i,
  output fsa_pkg::alu_rsp_t                   rsp_o,
  output logic [fsa_pkg::WIDE_BITS-1:0]       res_o,
  output logic [fsa_pkg::VALUE_BITS-1:0]      rem_o
);
  import fsa_pkg::*;

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [STEP_CNT_BITS-1:0]      cnt_q, cnt_d;
  logic [WIDE_BITS-1:0]          dvd_q, dvd_d;
  logic [VALUE_BITS-1:0]         rem_q, rem_d;
  logic [VALUE_BITS-1:0]         dvs_q, dvs_d;
  logic [WIDE_BITS-1:0]          step_dvd;
  logic [VALUE_BITS-1:0]         step_rem;
  logic [VALUE_BITS:0]           trial;
  logic [ACC_BITS+VALUE_BITS-1:0] mul_full;

  assign mul_full = a_i[ACC_BITS-1:0] * b_i;

  // one digit of restoring division, remainder stays below the divisor
  always_comb begin
    step_dvd = dvd_q;
    step_rem = rem_q;
    trial    = '0;
    for (int i = 0; i < DIGIT_BITS; i++) begin
      trial    = {step_rem, step_dvd[WIDE_BITS-1]};
      step_dvd = {step_dvd[WIDE_BITS-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        trial       = trial - {1'b0, dvs_q};
        step_dvd[0] = 1'b1;
      end
      step_rem = trial[VALUE_BITS-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (busy_q) begin
      dvd_d = step_dvd;
      rem_d = step_rem;
      cnt_d = cnt_q - STEP_CNT_BITS'(1);
      if (cnt_q == STEP_CNT_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      case (req_i.op)
        ALU_MUL: begin
          dvd_d  = WIDE_BITS'(mul_full);
          done_d = 1'b1;
        end
        ALU_DIV_WIDE: begin
          dvd_d  = a_i;
          rem_d  = '0;
          dvs_d  = b_i;
          cnt_d  = STEP_CNT_BITS'(WIDE_STEPS);
          busy_d = 1'b1;
        end
        default: begin
          // short operand sits at the top so only its digits are walked
          dvd_d  = a_i << (WIDE_BITS - SHORT_BITS);
          rem_d  = '0;
          dvs_d  = b_i;
          cnt_d  = STEP_CNT_BITS'(SHORT_STEPS);
          busy_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign res_o      = dvd_q;
  assign rem_o      = rem_q;

endmodule

// File: hw/rtl/fsa_seq.sv
// ----------------------------------------------------------------------------
// fsa_seq
// Sequencer and accumulator state, drives the shared arithmetic unit
// ----------------------------------------------------------------------------
module fsa_seq (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            int_mode_i,
  input  logic                            item_valid_i,
  output logic                            item_ready_o,
  input  logic [fsa_pkg::VALUE_BITS-1:0]  num_i,
  input  logic [fsa_pkg::VALUE_BITS-1:0]  den_i,
  input  logic                            last_i,
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output logic [fsa_pkg::ACC_BITS-1:0]    sum_num_o,
  output logic [fsa_pkg::ACC_BITS-1:0]    sum_den_o,
  output logic                            overflow_o,
  output fsa_pkg::alu_req_t               alu_req_o,
  output logic [fsa_pkg::WIDE_BITS-1:0]   alu_a_o,
  output logic [fsa_pkg::VALUE_BITS-1:0]  alu_b_o,
  input  fsa_pkg::alu_rsp_t               alu_rsp_i,
  input  logic [fsa_pkg::WIDE_BITS-1:0]   alu_res_i,
  input  logic [fsa_pkg::VALUE_BITS-1:0]  alu_rem_i
);
  import fsa_pkg::*;

  fsa_state_e             state_q, state_d;
  fsa_state_e             ret_q, ret_d;
  logic [VALUE_BITS-1:0]  ga_q, ga_d;
  logic [VALUE_BITS-1:0]  gb_q, gb_d;
  logic [VALUE_BITS-1:0]  n_q, n_d;
  logic [VALUE_BITS-1:0]  d_q, d_d;
  logic [VALUE_BITS-1:0]  dp_q, dp_d;
  logic [ACC_BITS-1:0]    ap_q, ap_d;
  logic [WIDE_BITS-1:0]   numw_q, numw_d;
  logic [WIDE_BITS-1:0]   denw_q, denw_d;
  logic                   last_q, last_d;
  logic [ACC_BITS-1:0]    acc_num_q, acc_num_d;
  logic [ACC_BITS-1:0]    acc_den_q, acc_den_d;
  logic                   ovf_q, ovf_d;
  logic                   done;
  logic                   too_big;

  assign done    = alu_rsp_i.done;
  assign too_big = (|numw_q[WIDE_BITS-1:ACC_BITS]) || (|denw_q[WIDE_BITS-1:ACC_BITS]);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:       if (item_valid_i) state_d = ST_GCD_CHK;
      ST_GCD_CHK:    state_d = (gb_q == '0) ? ret_q : ST_GCD_WAIT;
      ST_GCD_WAIT:   if (done) state_d = ST_GCD_CHK;
      ST_N_DIV:      state_d = ST_N_WAIT;
      ST_N_WAIT:     if (done) state_d = ST_D_DIV;
      ST_D_DIV:      state_d = ST_D_WAIT;
      ST_D_WAIT:     if (done) state_d = ST_G_MOD;
      ST_G_MOD:      state_d = ST_G_WAIT;
      ST_G_WAIT:     if (done) state_d = ST_GCD_CHK;
      ST_AP_DIV:     state_d = ST_AP_WAIT;
      ST_AP_WAIT:    if (done) state_d = ST_DP_DIV;
      ST_DP_DIV:     state_d = ST_DP_WAIT;
      ST_DP_WAIT:    if (done) state_d = ST_MUL_A;
      ST_MUL_A:      state_d = ST_MUL_A_WAIT;
      ST_MUL_A_WAIT: if (done) state_d = ST_MUL_B;
      ST_MUL_B:      state_d = ST_MUL_B_WAIT;
      ST_MUL_B_WAIT: if (done) state_d = ST_MUL_C;
      ST_MUL_C:      state_d = ST_MUL_C_WAIT;
      ST_MUL_C_WAIT: if (done) state_d = ST_R_MOD;
      ST_R_MOD:      state_d = ST_R_WAIT;
      ST_R_WAIT:     if (done) state_d = ST_GCD_CHK;
      ST_NUM_DIV:    state_d = ST_NUM_WAIT;
      ST_NUM_WAIT:   if (done) state_d = ST_DEN_DIV;
      ST_DEN_DIV:    state_d = ST_DEN_WAIT;
      ST_DEN_WAIT:   if (done) state_d = ST_UPDATE;
      ST_UPDATE:     state_d = last_q ? ST_EMIT : ST_IDLE;
      ST_EMIT:       if (res_ready_i) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  // unit requests and handshakes
  always_comb begin
    item_ready_o    = (state_q == ST_IDLE);
    res_valid_o     = (state_q == ST_EMIT);
    alu_req_o.start = 1'b0;
    alu_req_o.op    = ALU_DIV_SHORT;
    alu_a_o         = '0;
    alu_b_o         = '0;
    case (state_q)
      ST_GCD_CHK: begin
        alu_req_o.start = (gb_q != '0);
        alu_a_o         = WIDE_BITS'(ga_q);
        alu_b_o         = gb_q;
      end
      ST_N_DIV: begin
        alu_req_o.start = 1'b1;
        alu_a_o         = WIDE_BITS'(n_q);
        alu_b_o         = ga_q;
      end
      ST_D_DIV, ST_DP_DIV: begin
        alu_req_o.start = 1'b1;
        alu_a_o         = WIDE_BITS'(d_q);
        alu_b_o         = ga_q;
      end
      ST_G_MOD: begin
        alu_req_o.start = 1'b1;
        alu_req_o.op    = ALU_DIV_WIDE;
        alu_a_o         = WIDE_BITS'(acc_den_q);
        alu_b_o         = d_q;
      end
      ST_AP_DIV: begin
        alu_req_o.start = 1'b1;
        alu_req_o.op    = ALU_DIV_WIDE;
        alu_a_o         = WIDE_BITS'(acc_den_q);
        alu_b_o         = ga_q;
      end
      ST_MUL_A: begin
        alu_req_o.start = 1'b1;
        alu_req_o.op    = ALU_MUL;
        alu_a_o         = WIDE_BITS'(acc_num_q);
        alu_b_o         = dp_q;
      end
      ST_MUL_B: begin
        alu_req_o.start = 1'b1;
        alu_req_o.op    = ALU_MUL;
        alu_a_o         = WIDE_BITS'(ap_q);
        alu_b_o         = n_q;
      end
      ST_MUL_C: begin
        alu_req_o.start = 1'b1;
        alu_req_o.op    = ALU_MUL;
        alu_a_o         = WIDE_BITS'(ap_q);
        alu_b_o         = d_q;
      end
      ST_R_MOD, ST_NUM_DIV: begin
        alu_req_o.start = 1'b1;
        alu_req_o.op    = ALU_DIV_WIDE;
        alu_a_o         = numw_q;
        alu_b_o         = ga_q;
      end
      ST_DEN_DIV: begin
        alu_req_o.start = 1'b1;
        alu_req_o.op    = ALU_DIV_WIDE;
        alu_a_o         = denw_q;
        alu_b_o         = ga_q;
      end
      default: begin
        alu_req_o.start = 1'b0;
      end
    endcase
  end

  // working registers
  always_comb begin
    ret_d     = ret_q;
    ga_d      = ga_q;
    gb_d      = gb_q;
    n_d       = n_q;
    d_d       = d_q;
    dp_d      = dp_q;
    ap_d      = ap_q;
    numw_d    = numw_q;
    denw_d    = denw_q;
    last_d    = last_q;
    acc_num_d = acc_num_q;
    acc_den_d = acc_den_q;
    ovf_d     = ovf_q;
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          n_d    = num_i;
          d_d    = (int_mode_i || den_i == '0) ? VALUE_BITS'(1) : den_i;
          last_d = last_i;
          ga_d   = num_i;
          gb_d   = (int_mode_i || den_i == '0) ? VALUE_BITS'(1) : den_i;
          ret_d  = ST_N_DIV;
        end
      end
      ST_GCD_WAIT: begin
        if (done) begin
          ga_d = gb_q;
          gb_d = alu_rem_i;
        end
      end
      ST_N_WAIT:   if (done) n_d = alu_res_i[VALUE_BITS-1:0];
      ST_D_WAIT:   if (done) d_d = alu_res_i[VALUE_BITS-1:0];
      ST_G_WAIT: begin
        if (done) begin
          ga_d  = d_q;
          gb_d  = alu_rem_i;
          ret_d = ST_AP_DIV;
        end
      end
      ST_AP_WAIT:    if (done) ap_d = alu_res_i[ACC_BITS-1:0];
      ST_DP_WAIT:    if (done) dp_d = alu_res_i[VALUE_BITS-1:0];
      ST_MUL_A_WAIT: if (done) numw_d = alu_res_i;
      ST_MUL_B_WAIT: if (done) numw_d = numw_q + alu_res_i;
      ST_MUL_C_WAIT: if (done) denw_d = alu_res_i;
      ST_R_WAIT: begin
        // common factor of the new sum divides the denominators' gcd
        if (done) begin
          gb_d  = alu_rem_i;
          ret_d = ST_NUM_DIV;
        end
      end
      ST_NUM_WAIT: if (done) numw_d = alu_res_i;
      ST_DEN_WAIT: if (done) denw_d = alu_res_i;
      ST_UPDATE: begin
        if (too_big) begin
          acc_num_d = '1;
          acc_den_d = ACC_BITS'(1);
          ovf_d     = 1'b1;
        end else begin
          acc_num_d = numw_q[ACC_BITS-1:0];
          acc_den_d = denw_q[ACC_BITS-1:0];
        end
      end
      ST_EMIT: begin
        if (res_ready_i) begin
          acc_num_d = '0;
          acc_den_d = ACC_BITS'(1);
          ovf_d     = 1'b0;
        end
      end
      default: begin
        ret_d = ret_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      acc_num_q <= '0;
      acc_den_q <= ACC_BITS'(1);
      ovf_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      acc_num_q <= acc_num_d;
      acc_den_q <= acc_den_d;
      ovf_q     <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ret_q  <= ret_d;
    ga_q   <= ga_d;
    gb_q   <= gb_d;
    n_q    <= n_d;
    d_q    <= d_d;
    dp_q   <= dp_d;
    ap_q   <= ap_d;
    numw_q <= numw_d;
    denw_q <= denw_d;
    last_q <= last_d;
  end

  assign sum_num_o  = acc_num_q;
  assign sum_den_o  = acc_den_q;
  assign overflow_o = ovf_q;

endmodule

// File: hw/rtl/fraction_sum_accumulator.sv
// ----------------------------------------------------------------------------
// fraction_sum_accumulator
// Running sum of non-negative fractions kept in lowest terms, with a
// sticky saturation flag and an integer mode
// ----------------------------------------------------------------------------
// Each input transaction carries a fraction num/den and is added to the
// accumulator, which is then reduced to lowest terms; on a transaction with
// tlast set the reduced sum leaves on the master side and the accumulator is
// cleared. All arithmetic runs through one shared unit under a sequencer: a
// divider that retires four quotient bits per cycle and a 63x16 multiplier.
// One item takes five 80-bit divisions, three 16-bit divisions, three
// multiplies and three Euclidean gcd loops on 16-bit values, besides the
// accept, the three loop exits and the update; an item that closes a sum
// also passes the emit state. s_axis_tready is high only while the
// sequencer is idle; a finished sum waits in the output register, so the
// next item can already start. integer_mode is the only register, at byte
// address 0; a zero denominator counts as 1, and a sum that no longer fits
// 63 bits saturates to (2^63 - 1) / 1 and sets overflow until the sum
// leaves.
module fraction_sum_accumulator (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // register port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [fsa_pkg::APB_ADDR_BITS-1:0]      paddr,
  input  logic [fsa_pkg::APB_DATA_BITS-1:0]      pwdata,
  output logic [fsa_pkg::APB_DATA_BITS-1:0]      prdata,
  output logic                                   pready,
  // item input
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [fsa_pkg::IN_TDATA_BITS-1:0]      s_axis_tdata,   // num_in, den_in
  input  logic                                   s_axis_tlast,   // is_last
  // result output
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [fsa_pkg::OUT_TDATA_BITS-1:0]     m_axis_tdata,   // sum_num, sum_den
  output logic                                   m_axis_tuser    // overflow
);
  import fsa_pkg::*;

  logic                  int_mode_q, int_mode_d;
  logic                  cfg_write;
  logic                  res_valid;
  logic                  res_ready;
  logic [ACC_BITS-1:0]   res_num;
  logic [ACC_BITS-1:0]   res_den;
  logic                  res_ovf;
  logic                  out_valid_q, out_valid_d;
  logic [ACC_BITS-1:0]   out_num_q, out_num_d;
  logic [ACC_BITS-1:0]   out_den_q, out_den_d;
  logic                  out_ovf_q, out_ovf_d;
  alu_req_t              alu_req;
  alu_rsp_t              alu_rsp;
  logic [WIDE_BITS-1:0]  alu_a;
  logic [VALUE_BITS-1:0] alu_b;
  logic [WIDE_BITS-1:0]  alu_res;
  logic [VALUE_BITS-1:0] alu_rem;

  // register port, no wait states
  assign pready     = 1'b1;
  assign cfg_write  = psel && penable && pwrite && pready;
  assign int_mode_d = (cfg_write && paddr[2] == REG_INTEGER_MODE) ? pwdata[0] : int_mode_q;
  assign prdata     = (paddr[2] == REG_INTEGER_MODE) ? APB_DATA_BITS'(int_mode_q) : '0;

  fsa_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .int_mode_i   (int_mode_q),
    .item_valid_i (s_axis_tvalid),
    .item_ready_o (s_axis_tready),
    .num_i        (s_axis_tdata[VALUE_BITS-1:0]),
    .den_i        (s_axis_tdata[2*VALUE_BITS-1:VALUE_BITS]),
    .last_i       (s_axis_tlast),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .sum_num_o    (res_num),
    .sum_den_o    (res_den),
    .overflow_o   (res_ovf),
    .alu_req_o    (alu_req),
    .alu_a_o      (alu_a),
    .alu_b_o      (alu_b),
    .alu_rsp_i    (alu_rsp),
    .alu_res_i    (alu_res),
    .alu_rem_i    (alu_rem)
  );

  fsa_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .rsp_o  (alu_rsp),
    .res_o  (alu_res),
    .rem_o  (alu_rem)
  );

  // output register, takes a new sum while the old one is being drained
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_num_d   = out_num_q;
    out_den_d   = out_den_q;
    out_ovf_d   = out_ovf_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_num_d   = res_num;
      out_den_d   = res_den;
      out_ovf_d   = res_ovf;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_mode_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      int_mode_q  <= int_mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_num_q <= out_num_d;
    out_den_q <= out_den_d;
    out_ovf_q <= out_ovf_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_BITS'({out_den_q, out_num_q});
  assign m_axis_tuser  = out_ovf_q;

endmodule

// File: hw/rtl/fsa_checker.sv
// ----------------------------------------------------------------------------
// fsa_checker
// Port-level checks of the fraction sum accumulator, bound to the top level
// ----------------------------------------------------------------------------
module fsa_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   s_axis_tvalid,
  input logic                                   s_axis_tready,
  input logic                                   m_axis_tvalid,
  input logic                                   m_axis_tready,
  input logic [fsa_pkg::OUT_TDATA_BITS-1:0]     m_axis_tdata,
  input logic                                   m_axis_tuser
);
  import fsa_pkg::*;

  // a stalled result keeps its transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // a sum never leaves with a zero denominator
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[2*ACC_BITS-1:ACC_BITS] != '0)
    else $error("zero denominator on output");

  // once saturated the sum stays at its ceiling over one
  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[ACC_BITS-1:0] == '1 &&
      m_axis_tdata[2*ACC_BITS-1:ACC_BITS] == ACC_BITS'(1))
    else $error("overflow flagged with unsaturated sum");

  // an accepted item keeps the unit busy for the following cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while still working");

endmodule

bind fraction_sum_accumulator fsa_checker u_fsa_checker (.*);
